### sv/hkbt_pkg.sv
package hkbt_pkg;

   localparam int NUM_BUCKETS  = 64;
   localparam int BUCKET_SLOTS = 8;
   localparam int VALUE_BITS   = 32;
   localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;
   localparam int HASH_W       = 64;
   localparam int DIVISOR_W    = 7;
   localparam int BUCKET_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SLOT_W       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int ADDR_W       = $clog2(TOTAL_SLOTS);
   localparam int REM_W        = DIVISOR_W + 1;
   localparam int BIT_CNT_W    = $clog2(HASH_W);
   localparam int SCAN_CNT_W   = $clog2(BUCKET_SLOTS + 1);

   localparam logic [HASH_W-1:0]    SEED_HASH     = HASH_W'(5381);
   localparam logic [DIVISOR_W-1:0] BUCKET_RESET  = DIVISOR_W'(64);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  key_byte;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [HASH_W-1:0]     hash;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

endpackage

### sv/hkbt_mod_unit.sv
module hkbt_mod_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [hkbt_pkg::HASH_W-1:0]     dividend,
   input  logic [hkbt_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            done,
   output logic [hkbt_pkg::BUCKET_W-1:0]   remainder
);
   import hkbt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [HASH_W-1:0]    num_ff, num_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]     shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      shifted = {rem_ff[REM_W-2:0], num_ff[HASH_W-1]};
      if (start) begin
         busy_in = 1'b1;
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         // one quotient bit per cycle, msb first
         num_in = {num_ff[HASH_W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = BUCKET_W'(rem_ff);

endmodule

### sv/hkbt_slot_mem.sv
module hkbt_slot_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [hkbt_pkg::ADDR_W-1:0]   wr_addr,
   input  hkbt_pkg::slot_type            wr_data,
   input  logic                          rd_en,
   input  logic [hkbt_pkg::ADDR_W-1:0]   rd_addr,
   output hkbt_pkg::slot_type            rd_data
);
   import hkbt_pkg::*;

   slot_type mem [TOTAL_SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/hashed_key_bucket_table_unit.sv
// Hash table keyed by the 64-bit djb2 hash of a byte string. Key bytes arrive one per
// request and each nonzero byte is folded into the hash; a zero byte ends the key and
// runs insert, get or remove (any other opcode answers not found), answering with one
// response: the bit-serial modulo unit picks the bucket, the bucket's slots are read
// from the slot memory, and then the write back is made and the response posted.
// After reset a clearing pass writes all 512 slots, one slot per cycle, before the
// first request is taken. Nonzero bytes are taken while a response waits; a
// terminating byte waits until the previous response has been taken.
module hashed_key_bucket_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hkbt_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hkbt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [hkbt_pkg::DIVISOR_W-1:0]    csr_wdata
);
   import hkbt_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_ACT   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [DIVISOR_W-1:0]  bcount_ff;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [HASH_W-1:0]     key_hash_ff, key_hash_in;
   logic [1:0]            op_ff, op_in;
   logic [31:0]           val_ff, val_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [BUCKET_W-1:0]   bucket_ff, bucket_in;
   logic [SCAN_CNT_W-1:0] scan_ff, scan_in;
   logic                  chk_ff, chk_in;
   logic [SLOT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                  hit_ff, hit_in;
   logic [SLOT_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  free_ff, free_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  div_start, div_done;
   logic [DIVISOR_W-1:0]  divisor;
   logic [BUCKET_W-1:0]   remainder;
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   slot_type              wr_data, rd_data;

   always_comb begin
      if (bcount_ff == '0) begin
         divisor = DIVISOR_W'(1);
      end else if ({25'd0, bcount_ff} > 32'(NUM_BUCKETS)) begin
         divisor = DIVISOR_W'(NUM_BUCKETS);
      end else begin
         divisor = bcount_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || (req_data.key_byte != 8'd0));
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      key_hash_in  = key_hash_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      clr_in       = clr_ff;
      bucket_in    = bucket_ff;
      scan_in      = scan_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(32'(bucket_ff) * BUCKET_SLOTS + 32'(free_idx_ff));
      wr_data      = '{valid: 1'b1, hash: key_hash_ff, value: VALUE_BITS'(val_ff)};
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(32'(bucket_ff) * BUCKET_SLOTS + 32'(scan_ff));

      // slot read issued last cycle
      if (chk_ff) begin
         if (rd_data.valid && (rd_data.hash == key_hash_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
            hit_val_in = rd_data.value;
         end
         if (!rd_data.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(TOTAL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.key_byte != 8'd0) begin
                  hash_in = {hash_ff[HASH_W-6:0], 5'd0} + hash_ff
                          + {56'd0, req_data.key_byte};
               end else begin
                  key_hash_in = hash_ff;
                  hash_in     = SEED_HASH;
                  op_in       = req_data.opcode;
                  val_in      = req_data.value_in;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               bucket_in = remainder;
               scan_in   = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff == SCAN_CNT_W'(BUCKET_SLOTS)) begin
               state_in = S_ACT;
            end else begin
               rd_en      = 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = SLOT_W'(scan_ff);
               scan_in    = scan_ff + 1'b1;
            end
         end
         S_ACT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_NOT_FOUND, value_out: 32'd0};
            state_in     = S_IDLE;
            case (op_ff)
               OP_INSERT: begin
                  if (!hit_ff) begin
                     if (free_ff) begin
                        wr_en         = 1'b1;
                        rsp_in.status = ST_OK;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
               end
               OP_GET, OP_REMOVE: begin
                  if (hit_ff) begin
                     rsp_in = '{status: ST_OK, value_out: 32'(hit_val_ff)};
                     if (op_ff == OP_REMOVE) begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(32'(bucket_ff) * BUCKET_SLOTS + 32'(hit_idx_ff));
                        wr_data = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         bcount_ff    <= BUCKET_RESET;
         hash_ff      <= SEED_HASH;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hash_ff      <= hash_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            bcount_ff <= csr_wdata;
         end
      end
      key_hash_ff <= key_hash_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      bucket_ff   <= bucket_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   hkbt_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (key_hash_in),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (remainder)
   );

   hkbt_slot_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/hkbt_checker.sv
module hkbt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  hkbt_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  hkbt_pkg::rsp_type              rsp_data
);
   import hkbt_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a terminating byte never yields a response in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.key_byte == 8'd0) |=> !rsp_valid)
      else $error("response appeared too early");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK) || (rsp_data.status == ST_NOT_FOUND)
                    || (rsp_data.status == ST_FULL))
      else $error("unknown status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.value_out == 32'd0)
      else $error("failed request returned a value");

   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("request taken during clearing pass");

endmodule

bind hashed_key_bucket_table_unit hkbt_checker u_hkbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/hashed_key_bucket_table_unit_test.sv
module hashed_key_bucket_table_unit_test;
   import hkbt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [DIVISOR_W-1:0] csr_wdata;

   hashed_key_bucket_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // shadow of the table
   logic [HASH_W-1:0]     shadow_hash  [TOTAL_SLOTS];
   logic [VALUE_BITS-1:0] shadow_value [TOTAL_SLOTS];
   logic                  shadow_valid [TOTAL_SLOTS];
   logic [HASH_W-1:0]     key_hash;
   logic [DIVISOR_W-1:0]  divisor_reg;

   req_type pending_requests[$];
   rsp_type expected_responses[$];
   int  mismatches;
   bit  failed;
   bit  stim_done;
   int  hold_cycles;
   int  send_wait;
   int  recv_wait;
   bit  long_hold;
   req_type cur;

   // key pool so that lookups hit stored entries
   logic [7:0] key_pool [16][4];
   int         key_len  [16];

   task automatic apply_request(input req_type r);
      logic [HASH_W-1:0] h;
      int n, base, hit, i;
      rsp_type e;
      if (r.key_byte != 8'd0) begin
         key_hash = key_hash * 33 + HASH_W'(r.key_byte);
         return;
      end
      h = key_hash;
      n = (divisor_reg == 0) ? 1 : (divisor_reg > NUM_BUCKETS ? NUM_BUCKETS : divisor_reg);
      base = int'(h % HASH_W'(n)) * BUCKET_SLOTS;
      hit = -1;
      for (i = 0; i < BUCKET_SLOTS; i++)
         if (hit < 0 && shadow_valid[base+i] && shadow_hash[base+i] == h) hit = i;
      e.status = ST_NOT_FOUND;
      e.value_out = '0;
      if (r.opcode == OP_INSERT) begin
         if (hit < 0) begin
            e.status = ST_FULL;
            for (i = 0; i < BUCKET_SLOTS; i++)
               if (e.status == ST_FULL && !shadow_valid[base+i]) begin
                  shadow_valid[base+i] = 1'b1;
                  shadow_hash[base+i] = h;
                  shadow_value[base+i] = r.value_in;
                  e.status = ST_OK;
               end
         end
      end else if (r.opcode == OP_GET || r.opcode == OP_REMOVE) begin
         if (hit >= 0) begin
            e.status = ST_OK;
            e.value_out = shadow_value[base+hit];
            if (r.opcode == OP_REMOVE) shadow_valid[base+hit] = 1'b0;
         end
      end
      key_hash = SEED_HASH;
      expected_responses.push_back(e);
   endtask

   task automatic queue_byte(input logic [1:0] op, input logic [7:0] b,
                             input logic [31:0] v);
      req_type r;
      r.opcode = op;
      r.key_byte = b;
      r.value_in = v;
      pending_requests.push_back(r);
   endtask

   task automatic queue_key(input int k, input logic [1:0] op, input logic [31:0] v);
      int i;
      for (i = 0; i < key_len[k]; i++) queue_byte(2'($urandom), key_pool[k][i], $urandom);
      queue_byte(op, 8'd0, v);
   endtask

   task automatic wait_drained(input int extra);
      while (pending_requests.size() != 0 || expected_responses.size() != 0 || req_valid)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIVISOR_W-1:0] d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      divisor_reg = d;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (req_valid && req_ready) begin
         apply_request(req_data);
         req_valid <= 1'b0;
         send_wait <= $urandom_range(0, 12);
      end else if (!req_valid && send_wait > 0) begin
         send_wait <= send_wait - 1;
      end
   end

   always @(negedge clock) begin
      if (!reset && !req_valid && send_wait == 0 && pending_requests.size() != 0) begin
         cur = pending_requests.pop_front();
         req_data <= cur;
         req_valid <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_responses.pop_front();
            if (rsp_data.status !== e.status || rsp_data.value_out !== e.value_out) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d value %h, got status %0d value %h",
                           e.status, e.value_out, rsp_data.status, rsp_data.value_out);
            end
         end
         recv_wait <= $urandom_range(0, 12);
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
      end
   end

   always @(negedge clock) begin
      if (long_hold) rsp_ready <= 1'b0;
      else if (hold_cycles > 0) rsp_ready <= 1'b0;
      else rsp_ready <= (recv_wait == 0) && ($urandom_range(0, 3) != 0 || stim_done);
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (long_hold && hold_cycles == 0) hold_cycles <= 600;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   initial begin
      int i, j, k, phase;
      logic [1:0] op;
      mismatches = 0;
      failed = 1'b0;
      stim_done = 1'b0;
      long_hold = 1'b0;
      hold_cycles = 0;
      recv_wait = 0;
      key_hash = SEED_HASH;
      divisor_reg = BUCKET_RESET;
      for (i = 0; i < TOTAL_SLOTS; i++) shadow_valid[i] = 1'b0;
      for (k = 0; k < 16; k++) begin
         key_len[k] = $urandom_range(0, 4);
         for (j = 0; j < 4; j++) key_pool[k][j] = 8'($urandom_range(1, 255));
      end
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty key, extreme bytes, every opcode, duplicate
      queue_byte(OP_GET, 8'd0, 32'hFFFF_FFFF);
      queue_byte(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
      queue_byte(OP_INSERT, 8'd0, 32'h1);
      queue_byte(OP_GET, 8'd0, 32'h0);
      queue_byte(OP_UNUSED, 8'd0, 32'h0);
      queue_byte(OP_REMOVE, 8'd0, 32'h0);
      queue_byte(OP_REMOVE, 8'd0, 32'h0);
      queue_byte(OP_UNUSED, 8'hFF, 32'h0);
      queue_byte(OP_INSERT, 8'd0, 32'hA5A5_5A5A);
      queue_byte(OP_GET, 8'h01, 32'h0);
      queue_byte(OP_GET, 8'd0, 32'h0);
      wait_drained(100);

      // one bucket: ten inserts overflow it
      write_divisor(7'd1);
      for (i = 0; i < 10; i++) begin
         queue_byte(OP_INSERT, 8'(i + 1), 32'h0);
         queue_byte(OP_INSERT, 8'd0, $urandom);
      end
      // long receiver hold while requests keep coming
      long_hold = 1'b1;
      repeat (20) @(posedge clock);
      long_hold = 1'b0;
      wait_drained(100);
      write_divisor(7'd0);
      for (i = 0; i < 10; i++) begin
         queue_byte(OP_REMOVE, 8'(i + 1), 32'h0);
         queue_byte(OP_REMOVE, 8'd0, 32'h0);
      end
      wait_drained(100);

      // random phases over several divisors, the extremes among them
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_divisor(7'd127);
            1: write_divisor(7'd64);
            2: write_divisor(7'd2);
            3: write_divisor(7'($urandom_range(3, 63)));
            4: write_divisor(7'd65);
            default: write_divisor(7'd1);
         endcase
         for (i = 0; i < 35; i++) begin
            k = $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0) begin
               // noise: raw bytes, maybe unused opcode
               queue_byte(2'($urandom), 8'($urandom), $urandom);
               queue_byte(2'($urandom), 8'd0, $urandom);
            end else begin
               op = ($urandom_range(0, 2) == 0) ? OP_INSERT : 2'($urandom_range(0, 2));
               queue_key(k, op, $urandom);
            end
         end
         wait_drained(100);
      end

      stim_done = 1'b1;
      wait_drained(200);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/hkbt_pkg.sv
sv/hkbt_mod_unit.sv
sv/hkbt_slot_mem.sv
sv/hashed_key_bucket_table_unit.sv
sv/hkbt_checker.sv
tb/hashed_key_bucket_table_unit_test.sv
